// ===== hw/rtl/apc_pkg.sv =====
// shared types and constants of the alarm panel controller
`timescale 1ns / 1ps

package apc_pkg;

    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    // event kinds
    localparam logic [1:0] OP_KEY    = 2'd0;
    localparam logic [1:0] OP_TICK   = 2'd1;
    localparam logic [1:0] OP_SWITCH = 2'd2;

    // panel modes
    localparam logic [MODE_W-1:0] MODE_UNSET  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_EXIT   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SET    = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ENTRY  = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ALARM  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_REPORT = 3'd5;

    // special keys
    localparam logic [3:0] KEY_SUBMIT = 4'hB;
    localparam logic [3:0] KEY_DELETE = 4'hC;

    // switch samples
    localparam logic [7:0] SW_ENTRY_DOOR = 8'd1;
    localparam logic [7:0] SW_INTRUSION  = 8'd2;

    // recorded zones
    localparam logic [2:0] ZONE_ENTRY_DOOR = 3'd1;
    localparam logic [2:0] ZONE_INTRUSION  = 3'd2;
    localparam logic [2:0] ZONE_CODE_FAIL  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_USER_CODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXIT_TICKS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_TICKS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SILENCE_TICKS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BLINK_TICKS   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ATTEMPTS  = 3'd5;

    typedef struct packed {
        logic [15:0] user_code;
        logic [15:0] exit_ticks;
        logic [15:0] entry_ticks;
        logic [15:0] silence_ticks;
        logic [7:0]  blink_ticks;
        logic [2:0]  max_attempts;
    } cfg_t;

    typedef struct packed {
        logic [1:0] opcode;
        logic [3:0] key_value;
        logic [7:0] switch_value;
    } event_t;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic              sounder_on;
        logic [2:0]        zone_number;
        logic [2:0]        failed_count;
        logic [2:0]        keys_entered;
    } result_t;

endpackage

// ===== hw/rtl/apc_cfg_regs.sv =====
// configuration registers of the alarm panel controller
`timescale 1ns / 1ps

module apc_cfg_regs
    import apc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.user_code     <= 16'd4660;
            cfg_reg.exit_ticks    <= 16'd80;
            cfg_reg.entry_ticks   <= 16'd100;
            cfg_reg.silence_ticks <= 16'd60;
            cfg_reg.blink_ticks   <= 8'd5;
            cfg_reg.max_attempts  <= 3'd3;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_USER_CODE:     cfg_reg.user_code     <= cfg_wr_data;
                CFG_EXIT_TICKS:    cfg_reg.exit_ticks    <= cfg_wr_data;
                CFG_ENTRY_TICKS:   cfg_reg.entry_ticks   <= cfg_wr_data;
                CFG_SILENCE_TICKS: cfg_reg.silence_ticks <= cfg_wr_data;
                CFG_BLINK_TICKS:   cfg_reg.blink_ticks   <= cfg_wr_data[7:0];
                CFG_MAX_ATTEMPTS:  cfg_reg.max_attempts  <= cfg_wr_data[2:0];
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/apc_core.sv =====
// panel state registers and next-state logic for one event
`timescale 1ns / 1ps

module apc_core
    import apc_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step,
    input  event_t  evt,
    input  cfg_t    cfg,
    output result_t res_next
);

    localparam int POS_W     = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W     = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
    localparam int CODE_BITS = 4 * CODE_LENGTH;
    localparam logic [POS_W-1:0] FULL_POS = POS_W'(CODE_LENGTH);

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  match_reg, match_next;
    logic [2:0]        fail_reg, fail_next;
    logic [15:0]       countdown_reg, countdown_next;
    logic [7:0]        blink_reg, blink_next;
    logic              sounder_reg, sounder_next;
    logic              silenced_reg, silenced_next;
    logic [2:0]        zone_reg, zone_next;

    logic [3:0] keys_mem [CODE_LENGTH];

    logic [CODE_BITS-1:0] code_ext;
    logic [3:0]           code_sym [CODE_LENGTH];

    logic [POS_W-1:0]  pos_dec;
    logic [IDX_W-1:0]  idx_cur;
    logic [IDX_W-1:0]  idx_dec;
    logic              key_we;
    logic              buf_full;
    logic              code_ok;
    logic [3:0]        fail_inc;
    logic              do_enter;
    logic [MODE_W-1:0] enter_mode;

    assign code_ext = CODE_BITS'(cfg.user_code);

    // first key is compared with the top used nibble
    for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_sym
        assign code_sym[i] = code_ext[4*(CODE_LENGTH-1-i) +: 4];
    end

    assign pos_dec  = pos_reg - 1'b1;
    assign idx_cur  = pos_reg[IDX_W-1:0];
    assign idx_dec  = pos_dec[IDX_W-1:0];
    assign buf_full = (pos_reg >= FULL_POS);
    assign code_ok  = (match_reg == FULL_POS);
    assign fail_inc = {1'b0, fail_reg} + 4'd1;

    always_comb begin
        mode_next      = mode_reg;
        pos_next       = pos_reg;
        match_next     = match_reg;
        fail_next      = fail_reg;
        countdown_next = countdown_reg;
        blink_next     = blink_reg;
        sounder_next   = sounder_reg;
        silenced_next  = silenced_reg;
        zone_next      = zone_reg;
        key_we         = 1'b0;
        do_enter       = 1'b0;
        enter_mode     = mode_reg;

        case (evt.opcode)
            OP_KEY: begin
                if (mode_reg == MODE_REPORT) begin
                    if (evt.key_value == KEY_DELETE) begin
                        do_enter   = 1'b1;
                        enter_mode = MODE_UNSET;
                    end
                end else if (mode_reg inside {MODE_UNSET, MODE_EXIT, MODE_ENTRY, MODE_ALARM})
                begin
                    if (evt.key_value == KEY_SUBMIT) begin
                        if (buf_full) begin
                            pos_next   = '0;
                            match_next = '0;
                            case (mode_reg)
                                MODE_UNSET, MODE_EXIT: begin
                                    if (code_ok) begin
                                        fail_next  = '0;
                                        do_enter   = 1'b1;
                                        enter_mode = (mode_reg == MODE_UNSET) ? MODE_EXIT
                                                                              : MODE_UNSET;
                                    end else if (fail_inc >= {1'b0, cfg.max_attempts}) begin
                                        fail_next  = '0;
                                        zone_next  = ZONE_CODE_FAIL;
                                        do_enter   = 1'b1;
                                        enter_mode = MODE_ALARM;
                                    end else begin
                                        fail_next = fail_inc[2:0];
                                    end
                                end
                                MODE_ENTRY: begin
                                    if (code_ok) begin
                                        do_enter   = 1'b1;
                                        enter_mode = MODE_UNSET;
                                    end
                                end
                                MODE_ALARM: begin
                                    if (code_ok) begin
                                        do_enter   = 1'b1;
                                        enter_mode = MODE_REPORT;
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end else if (!buf_full) begin
                        if (evt.key_value == KEY_DELETE) begin
                            if (pos_reg != '0) begin
                                pos_next = pos_dec;
                                if (keys_mem[idx_dec] == code_sym[idx_dec]
                                    && match_reg != '0) begin
                                    match_next = match_reg - 1'b1;
                                end
                            end
                        end else begin
                            key_we   = 1'b1;
                            pos_next = pos_reg + 1'b1;
                            if (evt.key_value == code_sym[idx_cur]) begin
                                match_next = match_reg + 1'b1;
                            end
                        end
                    end
                end
            end
            OP_TICK: begin
                if (mode_reg == MODE_EXIT || mode_reg == MODE_ENTRY) begin
                    if (countdown_reg <= 16'd1) begin
                        countdown_next = '0;
                        do_enter       = 1'b1;
                        enter_mode     = (mode_reg == MODE_EXIT) ? MODE_SET : MODE_ALARM;
                    end else begin
                        countdown_next = countdown_reg - 16'd1;
                        if (blink_reg <= 8'd1) begin
                            sounder_next = ~sounder_reg;
                            blink_next   = cfg.blink_ticks;
                        end else begin
                            blink_next = blink_reg - 8'd1;
                        end
                    end
                end else if (mode_reg == MODE_ALARM && !silenced_reg) begin
                    if (countdown_reg <= 16'd1) begin
                        countdown_next = '0;
                        silenced_next  = 1'b1;
                        sounder_next   = 1'b0;
                    end else begin
                        countdown_next = countdown_reg - 16'd1;
                    end
                end
            end
            OP_SWITCH: begin
                case (mode_reg)
                    MODE_SET: begin
                        if (evt.switch_value == SW_ENTRY_DOOR) begin
                            zone_next  = ZONE_ENTRY_DOOR;
                            do_enter   = 1'b1;
                            enter_mode = MODE_ENTRY;
                        end else if (evt.switch_value == SW_INTRUSION) begin
                            zone_next  = ZONE_INTRUSION;
                            do_enter   = 1'b1;
                            enter_mode = MODE_ALARM;
                        end
                    end
                    MODE_EXIT: begin
                        if (evt.switch_value == SW_INTRUSION) begin
                            zone_next  = ZONE_INTRUSION;
                            do_enter   = 1'b1;
                            enter_mode = MODE_ALARM;
                        end
                    end
                    MODE_ENTRY: begin
                        if (evt.switch_value == SW_INTRUSION) begin
                            do_enter   = 1'b1;
                            enter_mode = MODE_ALARM;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        // mode change clears the code buffer and loads the new mode's timers
        if (do_enter) begin
            mode_next     = enter_mode;
            pos_next      = '0;
            match_next    = '0;
            sounder_next  = 1'b0;
            silenced_next = 1'b0;
            case (enter_mode)
                MODE_EXIT: begin
                    countdown_next = cfg.exit_ticks;
                    blink_next     = cfg.blink_ticks;
                end
                MODE_ENTRY: begin
                    countdown_next = cfg.entry_ticks;
                    blink_next     = cfg.blink_ticks;
                end
                MODE_ALARM: begin
                    countdown_next = cfg.silence_ticks;
                    sounder_next   = 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_UNSET;
            pos_reg       <= '0;
            match_reg     <= '0;
            fail_reg      <= '0;
            countdown_reg <= '0;
            blink_reg     <= '0;
            sounder_reg   <= 1'b0;
            silenced_reg  <= 1'b0;
            zone_reg      <= '0;
        end else if (step) begin
            mode_reg      <= mode_next;
            pos_reg       <= pos_next;
            match_reg     <= match_next;
            fail_reg      <= fail_next;
            countdown_reg <= countdown_next;
            blink_reg     <= blink_next;
            sounder_reg   <= sounder_next;
            silenced_reg  <= silenced_next;
            zone_reg      <= zone_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (step && key_we) begin
            keys_mem[idx_cur] <= evt.key_value;
        end
    end

    assign res_next.mode         = mode_next;
    assign res_next.sounder_on   = sounder_next;
    assign res_next.zone_number  = zone_next;
    assign res_next.failed_count = fail_next;
    assign res_next.keys_entered = 3'(pos_next);

endmodule

// ===== hw/rtl/alarm_panel_controller.sv =====
// alarm panel controller top level with input and result registers
// a transaction waits in the input register; its result is then registered
// throughput: one transaction per cycle unless a held result stalls on m_ready
// a held result does not block the input register while the result side is ready
// reset: synchronous active-low aresetn returns the panel to unset mode,
// clears counters, zone and sounder, and loads the default configuration
`timescale 1ns / 1ps

module alarm_panel_controller
    import apc_pkg::*;
#(
    parameter int CODE_LENGTH = 4
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [1:0]            s_opcode,
    input  logic [3:0]            s_key_value,
    input  logic [7:0]            s_switch_value,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [MODE_W-1:0]     m_mode,
    output logic                  m_sounder_on,
    output logic [2:0]            m_zone_number,
    output logic [2:0]            m_failed_count,
    output logic [2:0]            m_keys_entered,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data
);

    cfg_t    cfg;
    event_t  evt_reg;
    logic    in_valid_reg;
    result_t res_next;
    result_t res_reg;
    logic    out_valid_reg;
    logic    advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    apc_cfg_regs u_cfg_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .cfg         (cfg)
    );

    apc_core #(
        .CODE_LENGTH (CODE_LENGTH)
    ) u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (advance),
        .evt      (evt_reg),
        .cfg      (cfg),
        .res_next (res_next)
    );

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            evt_reg.opcode       <= s_opcode;
            evt_reg.key_value    <= s_key_value;
            evt_reg.switch_value <= s_switch_value;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_mode         = res_reg.mode;
    assign m_sounder_on   = res_reg.sounder_on;
    assign m_zone_number  = res_reg.zone_number;
    assign m_failed_count = res_reg.failed_count;
    assign m_keys_entered = res_reg.keys_entered;

endmodule
